[rtl/lkc_pkg.sv]
// Shared constants, command codes and types of the keyed LRU cache.
`default_nettype none
package lkc_pkg;

    localparam int CAPACITY_DEF   = 16;
    localparam int KEY_BITS_DEF   = 32;
    localparam int VALUE_BITS_DEF = 32;

    localparam int CMD_W      = 3;
    localparam int KEY_IN_W   = 32;
    localparam int VAL_IN_W   = 32;
    localparam int CTIME_W    = 32;
    localparam int FRAME_W    = 64;
    localparam int STAMP_W    = 64;
    localparam int STAT_W     = 32;
    localparam int COST_W     = 64;
    localparam int CNT_OUT_W  = 5;
    localparam int ME_W       = 5;
    localparam int AGE_W      = 32;
    localparam int CFG_DATA_W = 32;

    localparam logic [CMD_W-1:0] CMD_LOOKUP   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_CONTAINS = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CLEANUP  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd4;

    localparam logic CFG_MAX_ENTRIES = 1'b0;
    localparam logic CFG_STALE_AGE   = 1'b1;

    localparam logic [ME_W-1:0]  MAX_ENTRIES_RST = 5'd16;
    localparam logic [AGE_W-1:0] STALE_AGE_RST   = 32'd1000;

    typedef struct packed {
        logic match;
        logic older;
        logic stale;
    } t_scan_flags;

endpackage
`default_nettype wire

[rtl/lru_keyed_cache_with_aging_top.sv]
// Keyed fully associative cache with stamp-based LRU replacement and aging.
//
// Input channel: i_in_valid / o_in_stall carry one command word (lookup,
// insert, contains, cleanup, clear). Output channel: o_out_valid /
// i_out_stall carry one result word per command.
// Lookup, insert, contains and cleanup walk the table one entry per cycle
// through a single compare unit and the table read port, then enter the
// write state, where the table update and result word are registered.
// Clear and unknown commands go straight to the write state. Input stalls
// until the write is done, so one command is in flight at a time.
// A new word is taken while a previous result still waits on the output;
// the table update and result are held back while the output register is
// full and stalled.
// Configuration (i_cfg_we / i_cfg_idx / i_cfg_data) is to be written while
// idle, not enforced here. Reset empties the table, zeroes the counters
// and access stamp, loads max_entries=16, stale_age=1000: no clearing pass.
`default_nettype none
module lru_keyed_cache_with_aging_top import lkc_pkg::*; #(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int KEY_BITS   = KEY_BITS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [CMD_W-1:0]      i_command,
    input  logic [KEY_IN_W-1:0]   i_key,
    input  logic [VAL_IN_W-1:0]   i_payload,
    input  logic                  i_create_ok,
    input  logic [CTIME_W-1:0]    i_compile_time,
    input  logic [FRAME_W-1:0]    i_current_frame,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_hit,
    output logic                  o_status,
    output logic [VAL_IN_W-1:0]   o_payload_out,
    output logic                  o_evicted,
    output logic [KEY_IN_W-1:0]   o_evicted_key,
    output logic [CNT_OUT_W-1:0]  o_removed_count,
    output logic [CNT_OUT_W-1:0]  o_entry_count,
    output logic [STAT_W-1:0]     o_hit_total,
    output logic [STAT_W-1:0]     o_miss_total,
    output logic [COST_W-1:0]     o_cost_total
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int LW = (CW > ME_W) ? CW : ME_W;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SCAN  = 3'b010,
        S_WRITE = 3'b100
    } t_state;

    t_state r_state;

    logic [ME_W-1:0]       r_max_entries;
    logic [AGE_W-1:0]      r_stale_age;

    logic [CMD_W-1:0]      r_cmd;
    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_val;
    logic                  r_cok;
    logic [CTIME_W-1:0]    r_ctime;
    logic [FRAME_W-1:0]    r_frame;

    logic [CAPACITY-1:0]   r_valid;
    logic [CW-1:0]         r_count;

    logic [KEY_BITS-1:0]   mem_key   [CAPACITY];
    logic [VALUE_BITS-1:0] mem_val   [CAPACITY];
    logic [STAMP_W-1:0]    mem_stamp [CAPACITY];

    logic [IW-1:0]         r_idx;
    logic                  r_issued_all;
    logic                  r_pend;
    logic [IW-1:0]         r_pidx;
    logic                  r_rd_vbit;
    logic [KEY_BITS-1:0]   r_rd_key;
    logic [VALUE_BITS-1:0] r_rd_val;
    logic [STAMP_W-1:0]    r_rd_stamp;

    logic                  r_found;
    logic [IW-1:0]         r_fidx;
    logic [VALUE_BITS-1:0] r_fval;
    logic                  r_have_old;
    logic [IW-1:0]         r_old_idx;
    logic [STAMP_W-1:0]    r_old_stamp;
    logic [KEY_BITS-1:0]   r_old_key;
    logic                  r_have_free;
    logic [IW-1:0]         r_free_idx;
    logic [CW-1:0]         r_removed;

    logic [STAMP_W-1:0]    r_acc;
    logic [STAT_W-1:0]     r_hits;
    logic [STAT_W-1:0]     r_misses;
    logic [COST_W-1:0]     r_cost;

    logic                  r_out_valid;
    logic                  r_o_hit;
    logic                  r_o_status;
    logic [VAL_IN_W-1:0]   r_o_payload;
    logic                  r_o_evicted;
    logic [KEY_IN_W-1:0]   r_o_evicted_key;
    logic [CNT_OUT_W-1:0]  r_o_removed;
    logic [CNT_OUT_W-1:0]  r_o_count;

    t_scan_flags           flags;
    logic                  in_accept;
    logic                  in_scan_cmd;
    logic                  stale_hit;
    logic                  do_write;
    logic [LW-1:0]         me_ext;
    logic [LW-1:0]         cap_ext;
    logic [LW-1:0]         limit;
    logic [STAMP_W-1:0]    acc_inc;

    logic [STAMP_W-1:0]    n_acc;
    logic [STAT_W-1:0]     n_hits;
    logic [STAT_W-1:0]     n_misses;
    logic [COST_W-1:0]     n_cost;
    logic [CW-1:0]         n_count;
    logic [CW-1:0]         n_removed;
    logic                  n_hit;
    logic                  n_status;
    logic [VALUE_BITS-1:0] n_pay;
    logic                  add_req;
    logic                  evict;
    logic [IW-1:0]         slot;
    logic [IW-1:0]         wr_addr;
    logic                  wr_key_en;
    logic                  wr_val_en;
    logic                  wr_stamp_en;
    logic                  set_valid;
    logic                  clr_old;
    logic                  clear_all;

    assign in_accept   = i_in_valid & ~o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign in_scan_cmd = (i_command == CMD_LOOKUP) || (i_command == CMD_INSERT) ||
                         (i_command == CMD_CONTAINS) || (i_command == CMD_CLEANUP);
    assign do_write    = (r_state == S_WRITE) && !(r_out_valid && i_out_stall);
    assign stale_hit   = r_pend && (r_cmd == CMD_CLEANUP) && flags.stale;

    lkc_scan_unit #(
        .KEY_BITS(KEY_BITS)
    ) u_scan (
        .i_ent_valid (r_rd_vbit),
        .i_ent_key   (r_rd_key),
        .i_ent_stamp (r_rd_stamp),
        .i_key       (r_key),
        .i_frame     (r_frame),
        .i_stale_age (r_stale_age),
        .i_have_best (r_have_old),
        .i_best_stamp(r_old_stamp),
        .o_flags     (flags)
    );

    // effective entry limit, clamped to 1..CAPACITY
    always_comb begin
        me_ext  = LW'(r_max_entries);
        cap_ext = LW'(CAPACITY);
        if (me_ext == '0) begin
            limit = LW'(1);
        end else if (me_ext > cap_ext) begin
            limit = cap_ext;
        end else begin
            limit = me_ext;
        end
    end

    assign acc_inc = r_acc + STAMP_W'(1);

    always_comb begin
        n_acc       = r_acc;
        n_hits      = r_hits;
        n_misses    = r_misses;
        n_cost      = r_cost;
        n_removed   = '0;
        n_hit       = 1'b0;
        n_status    = 1'b0;
        n_pay       = '0;
        add_req     = 1'b0;
        wr_addr     = r_fidx;
        wr_key_en   = 1'b0;
        wr_val_en   = 1'b0;
        wr_stamp_en = 1'b0;
        clear_all   = 1'b0;
        case (r_cmd)
            CMD_LOOKUP: begin
                if (r_found) begin
                    n_hits      = r_hits + STAT_W'(1);
                    n_acc       = acc_inc;
                    wr_stamp_en = 1'b1;
                    n_hit       = 1'b1;
                    n_pay       = r_fval;
                end else begin
                    n_misses = r_misses + STAT_W'(1);
                    if (!r_cok) begin
                        n_status = 1'b1;
                    end else begin
                        n_acc   = acc_inc;
                        n_cost  = r_cost + COST_W'(r_ctime);
                        add_req = 1'b1;
                        n_pay   = r_val;
                    end
                end
            end
            CMD_INSERT: begin
                n_acc    = acc_inc;
                n_cost   = r_cost + COST_W'(r_ctime);
                n_misses = r_misses + STAT_W'(1);
                if (r_found) begin
                    wr_val_en   = 1'b1;
                    wr_stamp_en = 1'b1;
                end else begin
                    add_req = 1'b1;
                end
            end
            CMD_CONTAINS: begin
                n_hit = r_found;
                n_pay = r_found ? r_fval : '0;
            end
            CMD_CLEANUP: begin
                n_removed = r_removed;
            end
            CMD_CLEAR: begin
                n_removed = r_count;
                n_hits    = '0;
                n_misses  = '0;
                n_cost    = '0;
                clear_all = 1'b1;
            end
            default: begin
            end
        endcase

        evict = add_req && (LW'(r_count) >= limit);
        if (evict) begin
            slot = (r_have_free && (r_free_idx < r_old_idx)) ? r_free_idx : r_old_idx;
        end else begin
            slot = r_free_idx;
        end
        clr_old   = evict;
        set_valid = add_req;
        if (add_req) begin
            wr_addr     = slot;
            wr_key_en   = 1'b1;
            wr_val_en   = 1'b1;
            wr_stamp_en = 1'b1;
        end

        if (clear_all) begin
            n_count = '0;
        end else if (add_req && !evict) begin
            n_count = r_count + CW'(1);
        end else begin
            n_count = r_count;
        end
    end

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_entries <= MAX_ENTRIES_RST;
            r_stale_age   <= STALE_AGE_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_MAX_ENTRIES) begin
                r_max_entries <= i_cfg_data[ME_W-1:0];
            end
            if (i_cfg_idx == CFG_STALE_AGE) begin
                r_stale_age <= i_cfg_data[AGE_W-1:0];
            end
        end
    end

    // input word capture
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_cmd   <= i_command;
            r_key   <= KEY_BITS'(i_key);
            r_val   <= VALUE_BITS'(i_payload);
            r_cok   <= i_create_ok;
            r_ctime <= i_compile_time;
            r_frame <= i_current_frame;
        end
    end

    // sequencer and scan control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_idx        <= '0;
            r_issued_all <= 1'b0;
            r_pend       <= 1'b0;
            r_found      <= 1'b0;
            r_have_old   <= 1'b0;
            r_have_free  <= 1'b0;
            r_removed    <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    r_pend <= 1'b0;
                    if (in_accept) begin
                        r_idx        <= '0;
                        r_issued_all <= 1'b0;
                        r_found      <= 1'b0;
                        r_have_old   <= 1'b0;
                        r_have_free  <= 1'b0;
                        r_removed    <= '0;
                        r_state      <= in_scan_cmd ? S_SCAN : S_WRITE;
                    end
                end
                S_SCAN: begin
                    r_pend <= !r_issued_all;
                    if (!r_issued_all) begin
                        if (r_idx == IW'(CAPACITY - 1)) begin
                            r_issued_all <= 1'b1;
                        end else begin
                            r_idx <= r_idx + IW'(1);
                        end
                    end
                    if (r_pend) begin
                        if (flags.match && !r_found) begin
                            r_found <= 1'b1;
                        end
                        if (flags.older) begin
                            r_have_old <= 1'b1;
                        end
                        if (!r_rd_vbit && !r_have_free) begin
                            r_have_free <= 1'b1;
                        end
                        if (stale_hit) begin
                            r_removed <= r_removed + CW'(1);
                        end
                        if (r_pidx == IW'(CAPACITY - 1)) begin
                            r_state <= S_WRITE;
                        end
                    end
                end
                S_WRITE: begin
                    if (do_write) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // scan captures
    always_ff @(posedge i_clk) begin
        r_pidx <= r_idx;
        if (r_pend) begin
            if (flags.match && !r_found) begin
                r_fidx <= r_pidx;
                r_fval <= r_rd_val;
            end
            if (flags.older) begin
                r_old_idx   <= r_pidx;
                r_old_stamp <= r_rd_stamp;
                r_old_key   <= r_rd_key;
            end
            if (!r_rd_vbit && !r_have_free) begin
                r_free_idx <= r_pidx;
            end
        end
    end

    // entry table: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        r_rd_key   <= mem_key[r_idx];
        r_rd_val   <= mem_val[r_idx];
        r_rd_stamp <= mem_stamp[r_idx];
        r_rd_vbit  <= r_valid[r_idx];
        if (do_write && wr_key_en) begin
            mem_key[wr_addr] <= r_key;
        end
        if (do_write && wr_val_en) begin
            mem_val[wr_addr] <= r_val;
        end
        if (do_write && wr_stamp_en) begin
            mem_stamp[wr_addr] <= acc_inc;
        end
    end

    // valid bits and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= '0;
        end else if (stale_hit) begin
            r_valid[r_pidx] <= 1'b0;
            r_count         <= r_count - CW'(1);
        end else if (do_write) begin
            if (clear_all) begin
                r_valid <= '0;
            end else begin
                if (clr_old) begin
                    r_valid[r_old_idx] <= 1'b0;
                end
                if (set_valid) begin
                    r_valid[slot] <= 1'b1;
                end
            end
            r_count <= n_count;
        end
    end

    // statistics
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc    <= '0;
            r_hits   <= '0;
            r_misses <= '0;
            r_cost   <= '0;
        end else if (do_write) begin
            r_acc    <= n_acc;
            r_hits   <= n_hits;
            r_misses <= n_misses;
            r_cost   <= n_cost;
        end
    end

    // result word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (do_write) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_write) begin
            r_o_hit         <= n_hit;
            r_o_status      <= n_status;
            r_o_payload     <= VAL_IN_W'(n_pay);
            r_o_evicted     <= evict;
            r_o_evicted_key <= evict ? KEY_IN_W'(r_old_key) : '0;
            r_o_removed     <= CNT_OUT_W'(n_removed);
            r_o_count       <= CNT_OUT_W'(n_count);
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_hit           = r_o_hit;
    assign o_status        = r_o_status;
    assign o_payload_out   = r_o_payload;
    assign o_evicted       = r_o_evicted;
    assign o_evicted_key   = r_o_evicted_key;
    assign o_removed_count = r_o_removed;
    assign o_entry_count   = r_o_count;
    assign o_hit_total     = r_hits;
    assign o_miss_total    = r_misses;
    assign o_cost_total    = r_cost;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("occupancy above capacity");

    a_found_has_old: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRITE && r_found) |-> r_have_old)
        else $error("key match without any valid entry seen");

    a_write_gives_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_write |=> (r_out_valid && r_state == S_IDLE))
        else $error("table update without result word");

    a_evict_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_write && evict) |=> (r_count != '0))
        else $error("eviction left an empty table");

endmodule
`default_nettype wire

[rtl/lkc_scan_unit.sv]
// Shared per-entry compare unit: key match, oldest stamp and stale age.
`default_nettype none
module lkc_scan_unit import lkc_pkg::*; #(
    parameter int KEY_BITS = KEY_BITS_DEF
) (
    input  logic                i_ent_valid,
    input  logic [KEY_BITS-1:0] i_ent_key,
    input  logic [STAMP_W-1:0]  i_ent_stamp,
    input  logic [KEY_BITS-1:0] i_key,
    input  logic [FRAME_W-1:0]  i_frame,
    input  logic [AGE_W-1:0]    i_stale_age,
    input  logic                i_have_best,
    input  logic [STAMP_W-1:0]  i_best_stamp,
    output t_scan_flags         o_flags
);

    logic [STAMP_W-1:0] age;

    assign age = i_frame - i_ent_stamp;

    always_comb begin
        o_flags.match = i_ent_valid & (i_ent_key == i_key);
        o_flags.older = i_ent_valid & (!i_have_best || (i_ent_stamp < i_best_stamp));
        o_flags.stale = i_ent_valid & (age > STAMP_W'(i_stale_age));
    end

endmodule
`default_nettype wire

[verif/tb.sv]
// Self-checking testbench for the keyed LRU cache: directed cases, then random traffic.
`default_nettype none
module tb;
    import lkc_pkg::*;

    localparam int NSLOT       = CAPACITY_DEF;
    localparam int STALL_LIMIT = 5000;
    localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 3'd5;
    localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 3'd7;

    typedef struct packed {
        bit        hit;
        bit        status;
        bit [31:0] payload;
        bit        evicted;
        bit [31:0] ev_key;
        bit [4:0]  removed;
        bit [4:0]  count;
        bit [31:0] hits;
        bit [31:0] misses;
        bit [63:0] cost;
    } t_cache_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic                  i_cfg_idx = 1'b0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic [CMD_W-1:0]      i_command = '0;
    logic [KEY_IN_W-1:0]   i_key = '0;
    logic [VAL_IN_W-1:0]   i_payload = '0;
    logic                  i_create_ok = 1'b0;
    logic [CTIME_W-1:0]    i_compile_time = '0;
    logic [FRAME_W-1:0]    i_current_frame = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic                  o_hit;
    logic                  o_status;
    logic [VAL_IN_W-1:0]   o_payload_out;
    logic                  o_evicted;
    logic [KEY_IN_W-1:0]   o_evicted_key;
    logic [CNT_OUT_W-1:0]  o_removed_count;
    logic [CNT_OUT_W-1:0]  o_entry_count;
    logic [STAT_W-1:0]     o_hit_total;
    logic [STAT_W-1:0]     o_miss_total;
    logic [COST_W-1:0]     o_cost_total;

    lru_keyed_cache_with_aging_top i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_command(i_command), .i_key(i_key), .i_payload(i_payload),
        .i_create_ok(i_create_ok), .i_compile_time(i_compile_time),
        .i_current_frame(i_current_frame),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_hit(o_hit), .o_status(o_status), .o_payload_out(o_payload_out),
        .o_evicted(o_evicted), .o_evicted_key(o_evicted_key),
        .o_removed_count(o_removed_count), .o_entry_count(o_entry_count),
        .o_hit_total(o_hit_total), .o_miss_total(o_miss_total),
        .o_cost_total(o_cost_total)
    );

    always #2 i_clk = ~i_clk;

    // cache image
    bit        m_valid [NSLOT];
    bit [31:0] m_key   [NSLOT];
    bit [31:0] m_val   [NSLOT];
    bit [63:0] m_stamp [NSLOT];
    bit [63:0] m_access;
    bit [31:0] m_hits;
    bit [31:0] m_misses;
    bit [63:0] m_cost;
    bit [4:0]  m_max = MAX_ENTRIES_RST;
    bit [31:0] m_age = STALE_AGE_RST;

    t_cache_result pending_results[$];
    int errors = 0;
    int idle_in_pct = 0;
    int stall_pct = 0;
    int idle_cycles = 0;

    function automatic int find_slot(bit [31:0] k);
        for (int i = 0; i < NSLOT; i++)
            if (m_valid[i] && m_key[i] == k) return i;
        return -1;
    endfunction

    function automatic int live_count();
        int n;
        n = 0;
        for (int i = 0; i < NSLOT; i++) n += m_valid[i];
        return n;
    endfunction

    function automatic void place_entry(bit [31:0] k, bit [31:0] v, bit [63:0] st,
                                        output bit ev, output bit [31:0] evk);
        int lim;
        int old;
        ev = 1'b0;
        evk = '0;
        lim = (m_max < 1) ? 1 : (m_max > NSLOT) ? NSLOT : int'(m_max);
        if (live_count() >= lim) begin
            old = -1;
            for (int i = 0; i < NSLOT; i++)
                if (m_valid[i] && (old < 0 || m_stamp[i] < m_stamp[old])) old = i;
            if (old >= 0) begin
                m_valid[old] = 1'b0;
                ev = 1'b1;
                evk = m_key[old];
            end
        end
        for (int i = 0; i < NSLOT; i++) begin
            if (!m_valid[i]) begin
                m_valid[i] = 1'b1;
                m_key[i] = k;
                m_val[i] = v;
                m_stamp[i] = st;
                return;
            end
        end
    endfunction

    function automatic t_cache_result cache_step(logic [CMD_W-1:0] cmd, bit [31:0] k,
                                                 bit [31:0] v, bit cok, bit [31:0] ctime,
                                                 bit [63:0] frame);
        t_cache_result r;
        int s;
        bit ev;
        bit [31:0] evk;
        r = '0;
        ev = 1'b0;
        evk = '0;
        case (cmd)
            CMD_LOOKUP: begin
                s = find_slot(k);
                if (s >= 0) begin
                    m_hits++;
                    m_access++;
                    m_stamp[s] = m_access;
                    r.hit = 1'b1;
                    r.payload = m_val[s];
                end else begin
                    m_misses++;
                    if (!cok) begin
                        r.status = 1'b1;
                    end else begin
                        m_access++;
                        m_cost += 64'(ctime);
                        place_entry(k, v, m_access, ev, evk);
                        r.payload = v;
                    end
                end
            end
            CMD_INSERT: begin
                m_access++;
                m_cost += 64'(ctime);
                m_misses++;
                s = find_slot(k);
                if (s >= 0) begin
                    m_val[s] = v;
                    m_stamp[s] = m_access;
                end else begin
                    place_entry(k, v, m_access, ev, evk);
                end
            end
            CMD_CONTAINS: begin
                s = find_slot(k);
                if (s >= 0) begin
                    r.hit = 1'b1;
                    r.payload = m_val[s];
                end
            end
            CMD_CLEANUP: begin
                for (int i = 0; i < NSLOT; i++) begin
                    if (m_valid[i] && (frame - m_stamp[i]) > 64'(m_age)) begin
                        m_valid[i] = 1'b0;
                        r.removed++;
                    end
                end
            end
            CMD_CLEAR: begin
                r.removed = 5'(live_count());
                for (int i = 0; i < NSLOT; i++) m_valid[i] = 1'b0;
                m_hits = '0;
                m_misses = '0;
                m_cost = '0;
            end
            default: ;
        endcase
        r.evicted = ev;
        r.ev_key = evk;
        r.count = 5'(live_count());
        r.hits = m_hits;
        r.misses = m_misses;
        r.cost = m_cost;
        return r;
    endfunction

    function automatic void check_field(string name, bit [63:0] want, bit [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endfunction

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        t_cache_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $error("result word with no expectation");
                errors++;
            end else begin
                want = pending_results.pop_front();
                check_field("hit", want.hit, o_hit);
                check_field("status", want.status, o_status);
                check_field("payload_out", want.payload, o_payload_out);
                check_field("evicted", want.evicted, o_evicted);
                check_field("evicted_key", want.ev_key, o_evicted_key);
                check_field("removed_count", want.removed, o_removed_count);
                check_field("entry_count", want.count, o_entry_count);
                check_field("hit_total", want.hits, o_hit_total);
                check_field("miss_total", want.misses, o_miss_total);
                check_field("cost_total", want.cost, o_cost_total);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    // valid stays high after acceptance; a drain or next-call idle cycles lower it
    task automatic send_word(logic [CMD_W-1:0] cmd, bit [31:0] k, bit [31:0] v, bit cok,
                             bit [31:0] ctime, bit [63:0] frame);
        while ($urandom_range(99) < idle_in_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_command       <= cmd;
        i_key           <= k;
        i_payload       <= v;
        i_create_ok     <= cok;
        i_compile_time  <= ctime;
        i_current_frame <= frame;
        do @(posedge i_clk); while (o_in_stall);
        pending_results.push_back(cache_step(cmd, k, v, cok, ctime, frame));
    endtask

    task automatic wait_drain();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (NSLOT + 4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        if (idx == CFG_MAX_ENTRIES) m_max = data[4:0];
        else m_age = data;
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic test_lookup_paths();
        send_word(CMD_CONTAINS, '0, '0, 1'b0, '0, '0);
        send_word(CMD_LOOKUP, '1, '1, 1'b0, '1, '1);
        send_word(CMD_LOOKUP, '0, '1, 1'b1, '1, '0);
        send_word(CMD_LOOKUP, '0, '0, 1'b0, '0, '0);
        send_word(CMD_CONTAINS, '0, '1, 1'b1, '1, '1);
    endtask

    task automatic test_insert_overwrite();
        send_word(CMD_INSERT, '1, '0, 1'b0, '1, '1);
        send_word(CMD_INSERT, '0, 32'h5a5a_a5a5, 1'b1, 32'd3, '0);
    endtask

    task automatic test_unknown_commands();
        for (logic [CMD_W-1:0] c = CMD_UNUSED_LO; c <= CMD_UNUSED_HI; c++) begin
            send_word(c, $urandom, $urandom, 1'b1, $urandom, {$urandom, $urandom});
            if (c == CMD_UNUSED_HI) break;
        end
    endtask

    // table above the new limit loses one entry per addition
    task automatic test_capacity_eviction();
        wait_drain();
        write_reg(CFG_MAX_ENTRIES, 32'hffff_ffe1);
        send_word(CMD_INSERT, 32'd7, 32'd70, 1'b0, 32'd1, '0);
        send_word(CMD_INSERT, 32'd8, 32'd80, 1'b0, 32'd1, '0);
        send_word(CMD_LOOKUP, 32'd9, 32'd90, 1'b1, 32'd1, '0);
        wait_drain();
        write_reg(CFG_MAX_ENTRIES, 32'h0000_0000);
        send_word(CMD_INSERT, 32'd10, 32'd100, 1'b0, 32'd1, '0);
        wait_drain();
        write_reg(CFG_MAX_ENTRIES, 32'h0000_001f);
    endtask

    task automatic test_cleanup_aging();
        wait_drain();
        write_reg(CFG_STALE_AGE, 32'd0);
        send_word(CMD_CLEANUP, '0, '0, 1'b0, '0, 64'd0);
        send_word(CMD_INSERT, 32'd1, 32'd11, 1'b0, 32'd2, '0);
        send_word(CMD_CLEANUP, '0, '0, 1'b0, '0, m_access);
        send_word(CMD_CLEANUP, '0, '0, 1'b0, '0, m_access + 64'd1);
        wait_drain();
        write_reg(CFG_STALE_AGE, 32'hffff_ffff);
        send_word(CMD_INSERT, 32'd2, 32'd22, 1'b0, 32'd2, '0);
        send_word(CMD_CLEANUP, '0, '0, 1'b0, '0, m_access + 64'hffff_ffff);
        send_word(CMD_CLEANUP, '0, '0, 1'b0, '0, m_access + 64'h1_0000_0000);
    endtask

    task automatic test_clear_stats();
        send_word(CMD_INSERT, 32'd3, 32'd33, 1'b0, '1, '0);
        send_word(CMD_CLEAR, '1, '1, 1'b1, '1, '1);
        send_word(CMD_LOOKUP, 32'd3, 32'd34, 1'b1, 32'd5, '0);
    endtask

    task automatic random_word();
        int pick;
        logic [CMD_W-1:0] cmd;
        bit [31:0] k;
        bit [63:0] frame;
        pick = $urandom_range(99);
        if (pick < 40) cmd = CMD_LOOKUP;
        else if (pick < 65) cmd = CMD_INSERT;
        else if (pick < 82) cmd = CMD_CONTAINS;
        else if (pick < 95) cmd = CMD_CLEANUP;
        else if (pick < 97) cmd = CMD_CLEAR;
        else cmd = CMD_UNUSED_LO + 3'($urandom_range(0, 2));
        k = ($urandom_range(99) < 85) ? 32'($urandom_range(0, 23)) : $urandom;
        if ($urandom_range(99) < 70)
            frame = m_access + 64'(m_age) - 64'($urandom_range(0, 24));
        else
            frame = {$urandom, $urandom};
        send_word(cmd, k, $urandom, 1'($urandom), $urandom, frame);
    endtask

    task automatic test_random_traffic();
        int me_pick [8] = '{16, 1, 4, 0, 31, 8, 2, 16};
        bit [31:0] age_pick [8] = '{1000, 0, 5, 32'hffff_ffff, 12, 3, 1000, 20};
        for (int p = 0; p < 8; p++) begin
            wait_drain();
            write_reg(CFG_MAX_ENTRIES, ($urandom & 32'hffff_ffe0) | 32'(me_pick[p]));
            write_reg(CFG_STALE_AGE, age_pick[p]);
            case (p % 4)
                0: begin idle_in_pct = 0;  stall_pct = 0;  end
                1: begin idle_in_pct = 78; stall_pct = 0;  end
                2: begin idle_in_pct = 0;  stall_pct = 78; end
                default: begin idle_in_pct = 11; stall_pct = 11; end
            endcase
            for (int n = 0; n < 150; n++) begin
                if (p % 4 == 2 && n == 75) wait_drain();
                random_word();
            end
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_lookup_paths();
        test_insert_overwrite();
        test_unknown_commands();
        test_capacity_eviction();
        test_cleanup_aging();
        test_clear_stats();
        test_random_traffic();
        wait_drain();
        repeat (2 * NSLOT + 8) @(posedge i_clk);
        if (errors == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
`default_nettype wire
